@@ hdl/bsf_pkg.sv @@
// Shared constants, register codes and types of the beacon SSID filter.
`timescale 1ns / 1ps
`default_nettype none

package bsf_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned MAX_SSID_BYTES_DEF = 32;
  localparam int unsigned POSITION_BITS_DEF  = 16;

  // Frame layout
  localparam int unsigned LEAD_BYTES  = 4;
  localparam int unsigned BSSID_AT    = 16;
  localparam int unsigned BSSID_BYTES = 6;
  localparam int unsigned FIXED_PART  = 36;
  localparam logic [7:0]  BEACON_FC   = 8'h80;
  localparam logic [7:0]  FC_MASK     = 8'hFC;

  // Port widths
  localparam int unsigned SSID_BYTES_MAX = 32;
  localparam int unsigned CFG_INDEX_W    = 3;
  localparam int unsigned CFG_DATA_W     = 64;
  localparam int unsigned OUT_FIELD_W    = 315;
  localparam int unsigned OUT_TDATA_W    = 320;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_TARGET_LENGTH,
    CFG_TARGET_WORD0,
    CFG_TARGET_WORD1,
    CFG_TARGET_WORD2,
    CFG_TARGET_WORD3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PHASE_ID,
    PHASE_LEN,
    PHASE_VAL
  } tag_phase_t;

  typedef struct packed {
    logic        beacon;
    logic [47:0] bssid;
  } hdr_sum_t;

  typedef struct packed {
    logic       complete;
    logic [7:0] held_len;
  } walk_sum_t;

  typedef struct packed {
    logic [5:0]                          len;
    logic [SSID_BYTES_MAX-1:0][7:0]      bytes;
  } target_t;

  // Result fields, last member in the lowest bits
  typedef struct packed {
    logic [SSID_BYTES_MAX-1:0][7:0] words;
    logic [47:0]                    bssid;
    logic                           hit;
    logic [7:0]                     len;
    logic                           found;
    logic                           beacon;
  } result_t;

endpackage

`default_nettype wire

@@ hdl/bsf_hdr.sv @@
// Radiotap length, frame-control check, BSSID capture and byte position tracking.
`timescale 1ns / 1ps
`default_nettype none

module bsf_hdr #(
  parameter int unsigned POSITION_BITS = bsf_pkg::POSITION_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  logic [7:0]        frame_byte,
  input  logic              last,
  output logic              walk_en,
  output bsf_pkg::hdr_sum_t sum
);
  import bsf_pkg::*;

  localparam logic [POSITION_BITS-1:0] PosMax = '1;

  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [23:0]              lead_r, lead_nxt;
  logic [15:0]              ho_r, ho_nxt;
  logic                     type_ok_r, type_ok_nxt;
  logic [47:0]              bssid_r, bssid_nxt;
  logic [16:0]              idx_w, ho_w, len_w;
  logic [31:0]              lead_all;
  logic [15:0]              ho_new;
  logic [7:0]               fc_lead;

  always_comb begin
    idx_w       = 17'(pos_r);
    ho_w        = {1'b0, ho_r};
    pos_nxt     = (pos_r == PosMax) ? pos_r : pos_r + 1'b1;
    lead_all    = {frame_byte, lead_r};
    ho_new      = lead_all[31:16];
    fc_lead     = lead_all[8*ho_new[1:0] +: 8];
    lead_nxt    = lead_r;
    ho_nxt      = ho_r;
    type_ok_nxt = type_ok_r;
    bssid_nxt   = bssid_r;

    if (idx_w < 17'(LEAD_BYTES - 1)) begin
      lead_nxt[8*pos_r[1:0] +: 8] = frame_byte;
    end

    if (idx_w == 17'(LEAD_BYTES - 1)) begin
      // The 802.11 header may start inside the four bytes already seen.
      ho_nxt = ho_new;
      if (ho_new < 16'(LEAD_BYTES)) begin
        type_ok_nxt = (fc_lead & FC_MASK) == BEACON_FC;
      end
    end else if (idx_w > 17'(LEAD_BYTES - 1) && pos_r != PosMax) begin
      if (idx_w == ho_w) begin
        type_ok_nxt = (frame_byte & FC_MASK) == BEACON_FC;
      end
      if (idx_w >= ho_w + 17'(BSSID_AT) &&
          idx_w <  ho_w + 17'(BSSID_AT + BSSID_BYTES)) begin
        bssid_nxt = {bssid_r[39:0], frame_byte};
      end
    end
  end

  always_comb begin
    walk_en    = idx_w > 17'(LEAD_BYTES - 1) && idx_w >= ho_w + 17'(FIXED_PART);
    len_w      = 17'(pos_nxt);
    sum.beacon = len_w >= 17'(LEAD_BYTES) &&
                 ({1'b0, ho_nxt} + 17'(FIXED_PART)) <= len_w && type_ok_nxt;
    sum.bssid  = bssid_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      lead_r    <= '0;
      ho_r      <= '0;
      type_ok_r <= 1'b0;
      bssid_r   <= '0;
    end else if (acc) begin
      if (last) begin
        pos_r     <= '0;
        lead_r    <= '0;
        ho_r      <= '0;
        type_ok_r <= 1'b0;
        bssid_r   <= '0;
      end else begin
        pos_r     <= pos_nxt;
        lead_r    <= lead_nxt;
        ho_r      <= ho_nxt;
        type_ok_r <= type_ok_nxt;
        bssid_r   <= bssid_nxt;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/bsf_tag_walk.sv @@
// Tagged-parameter walker that holds the first SSID tag of the frame body.
`timescale 1ns / 1ps
`default_nettype none

module bsf_tag_walk #(
  parameter int unsigned MAX_SSID_BYTES = bsf_pkg::MAX_SSID_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            acc,
  input  logic                            walk_en,
  input  logic [7:0]                      frame_byte,
  input  logic                            last,
  output bsf_pkg::walk_sum_t              sum,
  output logic [MAX_SSID_BYTES-1:0][7:0]  store
);
  import bsf_pkg::*;

  tag_phase_t phase_r, phase_nxt;
  logic       is_ssid_r, is_ssid_nxt;
  logic [7:0] left_r, left_nxt, left_dec;
  logic       stopped_r, stopped_nxt;
  logic       complete_r, complete_nxt;
  logic [7:0] held_r, held_nxt;
  logic [7:0] at;
  logic [MAX_SSID_BYTES-1:0][7:0] store_r, store_nxt;

  // Next state
  always_comb begin
    phase_nxt    = phase_r;
    is_ssid_nxt  = is_ssid_r;
    left_nxt     = left_r;
    stopped_nxt  = stopped_r;
    complete_nxt = complete_r;
    held_nxt     = held_r;
    store_nxt    = store_r;
    at           = held_r - left_r;
    left_dec     = (left_r != 8'd0) ? left_r - 8'd1 : left_r;

    if (walk_en && !stopped_r) begin
      case (phase_r)
        PHASE_ID: begin
          is_ssid_nxt = frame_byte == 8'd0;
          phase_nxt   = PHASE_LEN;
        end
        PHASE_LEN: begin
          left_nxt = frame_byte;
          if (is_ssid_r) begin
            // An empty SSID marks a hidden network and ends the walk.
            if (frame_byte == 8'd0) begin
              stopped_nxt = 1'b1;
            end else begin
              held_nxt  = frame_byte;
              phase_nxt = PHASE_VAL;
            end
          end else begin
            phase_nxt = (frame_byte == 8'd0) ? PHASE_ID : PHASE_VAL;
          end
        end
        PHASE_VAL: begin
          if (is_ssid_r) begin
            for (int i = 0; i < MAX_SSID_BYTES; i++) begin
              if (at == 8'(i)) begin
                store_nxt[i] = frame_byte;
              end
            end
          end
          left_nxt = left_dec;
          if (left_dec == 8'd0) begin
            if (is_ssid_r) begin
              complete_nxt = 1'b1;
              stopped_nxt  = 1'b1;
            end else begin
              phase_nxt = PHASE_ID;
            end
          end
        end
        default: begin
          phase_nxt = PHASE_ID;
        end
      endcase
    end
  end

  // Outputs carry the state after this byte, so the final byte is included.
  always_comb begin
    sum.complete = complete_nxt;
    sum.held_len = held_nxt;
    store        = store_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PHASE_ID;
      is_ssid_r  <= 1'b1;
      left_r     <= '0;
      stopped_r  <= 1'b0;
      complete_r <= 1'b0;
      held_r     <= '0;
    end else if (acc) begin
      if (last) begin
        phase_r    <= PHASE_ID;
        is_ssid_r  <= 1'b1;
        left_r     <= '0;
        stopped_r  <= 1'b0;
        complete_r <= 1'b0;
        held_r     <= '0;
      end else begin
        phase_r    <= phase_nxt;
        is_ssid_r  <= is_ssid_nxt;
        left_r     <= left_nxt;
        stopped_r  <= stopped_nxt;
        complete_r <= complete_nxt;
        held_r     <= held_nxt;
      end
    end
  end

  // Entries past the held length are masked at the result, so no clearing.
  always_ff @(posedge clk) begin
    if (acc) begin
      store_r <= store_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/bsf_result.sv @@
// Target comparison, field masking and the result output register.
`timescale 1ns / 1ps
`default_nettype none

module bsf_result #(
  parameter int unsigned MAX_SSID_BYTES = bsf_pkg::MAX_SSID_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            acc_last,
  input  bsf_pkg::hdr_sum_t               hdr,
  input  bsf_pkg::walk_sum_t              walk,
  input  logic [MAX_SSID_BYTES-1:0][7:0]  store,
  input  bsf_pkg::target_t                target,
  input  logic                            out_tready,
  output logic                            out_valid,
  output bsf_pkg::result_t                res
);
  import bsf_pkg::*;

  logic [SSID_BYTES_MAX-1:0][7:0] store_ext;
  logic                           found;
  logic                           len_ok;
  logic                           bytes_eq;
  result_t                        res_nxt;
  result_t                        res_r;
  logic                           valid_r;

  always_comb begin
    store_ext                   = '0;
    store_ext[MAX_SSID_BYTES-1:0] = store;
    found                       = hdr.beacon && walk.complete;

    res_nxt.words = '0;
    for (int i = 0; i < SSID_BYTES_MAX; i++) begin
      if (found && 8'(i) < walk.held_len) begin
        res_nxt.words[i] = store_ext[i];
      end
    end

    // A tag longer than the store, or a longer target, can never match.
    len_ok   = target.len != 6'd0 && {2'b00, target.len} == walk.held_len &&
               target.len <= 6'(MAX_SSID_BYTES);
    bytes_eq = 1'b1;
    for (int i = 0; i < SSID_BYTES_MAX; i++) begin
      if (6'(i) < target.len && target.bytes[i] != store_ext[i]) begin
        bytes_eq = 1'b0;
      end
    end

    res_nxt.beacon = hdr.beacon;
    res_nxt.found  = found;
    res_nxt.len    = found ? walk.held_len : 8'd0;
    res_nxt.hit    = found && len_ok && bytes_eq;
    res_nxt.bssid  = hdr.beacon ? hdr.bssid : 48'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (acc_last) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_last) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = valid_r;
  assign res       = res_r;

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    acc_last |=> valid_r)
    else $error("final byte accepted without a result following");

  a_not_beacon_zero: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !res_r.beacon |-> !res_r.found && res_r.bssid == 48'd0 && !res_r.hit)
    else $error("non-beacon result carries beacon fields");

  a_hit_needs_ssid: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && res_r.hit |-> res_r.found && res_r.len != 8'd0)
    else $error("target hit without a held SSID");

  a_no_ssid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !res_r.found |-> res_r.words == '0 && res_r.len == 8'd0)
    else $error("SSID bytes reported without a found SSID");

endmodule

`default_nettype wire

@@ hdl/beacon_ssid_filter.sv @@
// Top level of the beacon SSID filter: stream ports, target registers and block wiring.
`timescale 1ns / 1ps
`default_nettype none

// The filter takes a captured frame (radiotap header then 802.11 frame) one
// byte per cycle and gives one result transaction per frame, in the cycle
// after the byte marked by in_tlast is accepted. Every byte is parsed as it is
// accepted by the header tracker and the tag walker, so a new byte is taken on
// each clock; the only stall is on a final byte while the output register
// still holds a result that has not been taken. The longest path is the SSID
// byte write followed by the 32-byte comparison against the target. Target
// registers should be written only between frames.
module beacon_ssid_filter #(
  parameter int unsigned MAX_SSID_BYTES = bsf_pkg::MAX_SSID_BYTES_DEF,
  parameter int unsigned POSITION_BITS  = bsf_pkg::POSITION_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [7:0]                         in_tdata,   // frame_byte
  input  logic                               in_tlast,   // end_of_frame
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // is_beacon, ssid_found, ssid_length[7:0], target_hit, bssid_value[47:0],
  // ssid_word0..3 [63:0] each, zero pad
  output logic [bsf_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bsf_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [bsf_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import bsf_pkg::*;

  logic                           acc;
  logic                           acc_last;
  logic                           walk_en;
  hdr_sum_t                       hdr_sum;
  walk_sum_t                      walk_sum;
  logic [MAX_SSID_BYTES-1:0][7:0] store;
  logic [5:0]                     target_len_r;
  logic [SSID_BYTES_MAX-1:0][7:0] target_bytes_r;
  target_t                        target;
  result_t                        res;

  assign in_tready = !out_tvalid || out_tready || !in_tlast;
  assign acc       = in_tvalid && in_tready;
  assign acc_last  = acc && in_tlast;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_len_r   <= '0;
      target_bytes_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TARGET_LENGTH: target_len_r          <= cfg_data[5:0];
        CFG_TARGET_WORD0:  target_bytes_r[7:0]   <= cfg_data;
        CFG_TARGET_WORD1:  target_bytes_r[15:8]  <= cfg_data;
        CFG_TARGET_WORD2:  target_bytes_r[23:16] <= cfg_data;
        CFG_TARGET_WORD3:  target_bytes_r[31:24] <= cfg_data;
        default: begin
          target_len_r <= target_len_r;
        end
      endcase
    end
  end

  assign target.len   = target_len_r;
  assign target.bytes = target_bytes_r;

  bsf_hdr #(
    .POSITION_BITS (POSITION_BITS)
  ) u_hdr (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .frame_byte (in_tdata),
    .last       (in_tlast),
    .walk_en    (walk_en),
    .sum        (hdr_sum)
  );

  bsf_tag_walk #(
    .MAX_SSID_BYTES (MAX_SSID_BYTES)
  ) u_tag_walk (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .walk_en    (walk_en),
    .frame_byte (in_tdata),
    .last       (in_tlast),
    .sum        (walk_sum),
    .store      (store)
  );

  bsf_result #(
    .MAX_SSID_BYTES (MAX_SSID_BYTES)
  ) u_result (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc_last   (acc_last),
    .hdr        (hdr_sum),
    .walk       (walk_sum),
    .store      (store),
    .target     (target),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .res        (res)
  );

  assign out_tdata = {(OUT_TDATA_W - OUT_FIELD_W)'(0), res};

endmodule

`default_nettype wire
